[src/stdf_pkg.sv]
// ----------------------------------------------------------------------------
// stdf_pkg - shared types and constants of the sensor telegram deframer
// Character codes, register indexes, sequencer states and the request and
// response types of the shared arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package stdf_pkg;

    localparam int unsigned FRAME_BYTES_DEF = 6;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned ID_W     = 2;

    // framing and payload characters
    localparam logic [7:0] STX_CODE   = 8'h02;
    localparam logic [7:0] ETX_CODE   = 8'h03;
    localparam logic [7:0] CHR_A      = 8'h41;
    localparam logic [7:0] CHR_B      = 8'h42;
    localparam logic [7:0] CHR_X      = 8'h58;
    localparam logic [7:0] CHR_PLUS   = 8'h2B;
    localparam logic [7:0] CHR_MINUS  = 8'h2D;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_NINE   = 8'h39;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] VALUE_BIAS = 8'd50;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_B = 1'b1;

    // sensor codes on the result
    localparam logic [ID_W-1:0] ID_NONE = 2'd0;
    localparam logic [ID_W-1:0] ID_A    = 2'd1;
    localparam logic [ID_W-1:0] ID_B    = 2'd2;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MAC10
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [7:0]  a;
        logic [7:0]  b;
    } t_alu_req;

    typedef struct packed {
        logic [7:0]  y;
        logic        lt;     // signed a < b
    } t_alu_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_SIGN,
        ST_BIAS,
        ST_OFFS,
        ST_MIN,
        ST_MAX,
        ST_DONE
    } t_state;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHR_SPACE) || ((c >= CHR_TAB) && (c <= CHR_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHR_ZERO) && (c <= CHR_NINE);
    endfunction

endpackage

`default_nettype wire

[src/stdf_ram.sv]
// ----------------------------------------------------------------------------
// stdf_ram - generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stdf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 6
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[src/stdf_alu.sv]
// ----------------------------------------------------------------------------
// stdf_alu - shared 8-bit arithmetic unit
// Add, subtract, times-ten accumulate (mod 256) and a signed compare.
// ----------------------------------------------------------------------------
`default_nettype none

module stdf_alu (
    input  wire stdf_pkg::t_alu_req i_req,
    output stdf_pkg::t_alu_rsp      o_rsp
);

    import stdf_pkg::*;

    logic [10:0] mac;

    // acc*10 = acc*8 + acc*2
    assign mac = {i_req.a, 3'b000} + {2'b00, i_req.a, 1'b0} + {3'b000, i_req.b};

    always_comb begin
        unique case (i_req.op)
            ALU_ADD:   o_rsp.y = i_req.a + i_req.b;
            ALU_SUB:   o_rsp.y = i_req.a - i_req.b;
            ALU_MAC10: o_rsp.y = mac[7:0];
            default:   o_rsp.y = i_req.a;
        endcase
        o_rsp.lt = $signed(i_req.a) < $signed(i_req.b);
    end

endmodule

`default_nettype wire

[src/sensor_telegram_deframer.sv]
// ----------------------------------------------------------------------------
// sensor_telegram_deframer - STX/ETX telegram deframer with additive checksum
// Assembles radio bytes into telegrams, checks the sum and converts the
// decimal payload into a corrected per-sensor reading with min/max tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side: one received item per handshake, tdata = rx_byte, tuser = func
//   (1 clears the min/max store). Master side: one result item per ETX that
//   closes an open telegram. Offsets are written through i_cfg_* while idle.
// Throughput: ordinary bytes, STX and clears go one per cycle; ready stays high.
//   An ETX closing a good telegram from sensor A or B walks the stored payload,
//   one character per cycle through the RAM read port, then takes up to five
//   steps on the shared unit (sign, bias, offset, minimum, maximum) before the
//   output step; it walks at most FRAME_BYTES - 2 characters. A zero conversion
//   skips the offset step, an unseen sensor skips the maximum. Any other ETX
//   goes straight to the output step. Ready is low until the result has been
//   written to the output register.
// Reset: synchronous, active low. Offsets, sensor values, min/max and the
//   framing state go to zero; no telegram is open.
// Stall: results sit in an output register. While it is full the block still
//   takes items that give no result; the next result waits in the sequencer
//   (ready low) until the register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_telegram_deframer #(
    parameter int unsigned FRAME_BYTES = stdf_pkg::FRAME_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [stdf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [7:0]                      i_cfg_data,
    // received items
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,  // [7:0] rx_byte
    input  wire logic [0:0]                      s_axis_tuser,  // [0] func
    // result items
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [23:0]                          m_axis_tdata,  // [7:0] reading,
                                                                // [15:8] lowest,
                                                                // [23:16] highest
    output logic [3:0]                           m_axis_tuser   // [0] frame_good,
                                                                // [2:1] sensor_id,
                                                                // [3] battery_low
);

    import stdf_pkg::*;

    localparam int unsigned IW = $clog2(FRAME_BYTES);
    localparam int unsigned CW = $clog2(FRAME_BYTES + 1);

    // configuration
    logic signed [7:0] r_offset [2];

    // framing
    logic          r_in_frame;
    logic [CW-1:0] r_fill;
    logic [7:0]    r_sum;
    logic [7:0]    r_last;
    logic [7:0]    r_byte0;
    logic          r_byte1_x;

    // sequencer
    t_state        r_state, n_state;
    logic [CW-1:0] r_end;
    logic [IW-1:0] r_idx;
    logic          r_lead;
    logic          r_neg;
    logic [7:0]    r_acc;
    logic          r_id;      // 0 sensor A, 1 sensor B

    // sensor store
    logic [7:0]    r_value [2];
    logic [7:0]    r_min   [2];
    logic [7:0]    r_max   [2];
    logic [1:0]    r_seen;

    // pending result
    logic          r_res_good;
    logic          r_res_known;
    logic          r_res_batt;

    // output register
    logic          r_m_valid;
    logic [23:0]   r_m_tdata;
    logic [3:0]    r_m_tuser;

    // shared unit and frame store
    t_alu_req      alu_req;
    t_alu_rsp      alu_rsp;
    logic [7:0]    ram_rdata;
    logic [IW-1:0] ram_raddr;
    logic          ram_we;

    logic          in_acc;
    logic          func;
    logic [7:0]    rx;
    logic [CW-1:0] idx_nxt;
    logic          out_free;
    logic          sum_ok;
    logic          is_a;
    logic          is_b;

    assign func     = s_axis_tuser[0];
    assign rx       = s_axis_tdata;
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign idx_nxt  = CW'(r_idx) + CW'(1);
    assign out_free = !r_m_valid || m_axis_tready;
    // last byte equals the sum of the others: total == 2 * last
    assign sum_ok   = (r_sum == {r_last[6:0], 1'b0});
    assign is_a     = (r_fill >= CW'(2)) && (r_byte0 == CHR_A);
    assign is_b     = (r_fill >= CW'(2)) && (r_byte0 == CHR_B);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    assign ram_we    = in_acc && !func && (rx != STX_CODE) && (rx != ETX_CODE)
                       && r_in_frame && (r_fill < CW'(FRAME_BYTES));
    assign ram_raddr = (r_state == ST_WALK) ? idx_nxt[IW-1:0] : IW'(1);

    stdf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[IW-1:0]),
        .i_wdata (rx),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    stdf_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // operand selection for the shared unit
    always_comb begin
        alu_req.op = ALU_ADD;
        alu_req.a  = r_sum;
        alu_req.b  = rx;
        unique case (r_state)
            ST_IDLE: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = r_sum;
                alu_req.b  = rx;
            end
            ST_WALK: begin
                alu_req.op = ALU_MAC10;
                alu_req.a  = r_acc;
                alu_req.b  = {4'h0, ram_rdata[3:0]};
            end
            ST_SIGN: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = 8'h00;
                alu_req.b  = r_acc;
            end
            ST_BIAS: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = r_acc;
                alu_req.b  = VALUE_BIAS;
            end
            ST_OFFS: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = r_acc;
                alu_req.b  = r_offset[r_id];
            end
            ST_MIN: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = r_acc;
                alu_req.b  = r_min[r_id];
            end
            ST_MAX: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = r_max[r_id];
                alu_req.b  = r_acc;
            end
            ST_DONE: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = r_acc;
                alu_req.b  = 8'h00;
            end
            default: begin
                alu_req.op = ALU_ADD;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && !func && (rx == ETX_CODE) && r_in_frame) begin
                    if ((r_fill != '0) && sum_ok && (is_a || is_b)) begin
                        n_state = (r_fill >= CW'(3)) ? ST_WALK : ST_SIGN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_WALK: begin
                if (r_lead && (is_blank(ram_rdata) || is_digit(ram_rdata) ||
                               (ram_rdata == CHR_PLUS) || (ram_rdata == CHR_MINUS))) begin
                    n_state = (idx_nxt < r_end) ? ST_WALK : ST_SIGN;
                end else if (!r_lead && is_digit(ram_rdata)) begin
                    n_state = (idx_nxt < r_end) ? ST_WALK : ST_SIGN;
                end else begin
                    n_state = ST_SIGN;
                end
            end
            ST_SIGN: n_state = ST_BIAS;
            ST_BIAS: n_state = (r_acc == 8'h00) ? ST_MIN : ST_OFFS;
            ST_OFFS: n_state = ST_MIN;
            ST_MIN:  n_state = r_seen[r_id] ? ST_MAX : ST_DONE;
            ST_MAX:  n_state = ST_DONE;
            ST_DONE: n_state = out_free ? ST_IDLE : ST_DONE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset[0] <= '0;
            r_offset[1] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_OFFSET_A: r_offset[0] <= i_cfg_data;
                REG_OFFSET_B: r_offset[1] <= i_cfg_data;
                default:      r_offset[0] <= r_offset[0];
            endcase
        end
    end

    // framing and sensor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_fill     <= '0;
            r_sum      <= '0;
            r_seen     <= '0;
            r_value[0] <= '0;
            r_value[1] <= '0;
            r_min[0]   <= '0;
            r_min[1]   <= '0;
            r_max[0]   <= '0;
            r_max[1]   <= '0;
        end else begin
            if (in_acc) begin
                if (func) begin
                    r_seen <= '0;
                end else if ((rx == ETX_CODE) && r_in_frame) begin
                    r_in_frame <= 1'b0;
                    r_fill     <= '0;
                end else if (rx == STX_CODE) begin
                    r_in_frame <= 1'b1;
                    r_fill     <= '0;
                    r_sum      <= '0;
                end else if (r_in_frame) begin
                    if (r_fill < CW'(FRAME_BYTES)) begin
                        r_fill <= r_fill + CW'(1);
                        r_sum  <= alu_rsp.y;
                    end else begin
                        // overflow drops the telegram
                        r_in_frame <= 1'b0;
                        r_fill     <= '0;
                    end
                end
            end
            if (r_state == ST_MIN) begin
                r_value[r_id] <= r_acc;
                if (!r_seen[r_id]) begin
                    r_min[r_id]  <= r_acc;
                    r_max[r_id]  <= r_acc;
                    r_seen[r_id] <= 1'b1;
                end else if (alu_rsp.lt) begin
                    r_min[r_id] <= r_acc;
                end
            end
            if ((r_state == ST_MAX) && alu_rsp.lt) begin
                r_max[r_id] <= r_acc;
            end
        end
    end

    // captured telegram bytes (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_last <= rx;
            if (r_fill == '0) begin
                r_byte0 <= rx;
            end
            if (r_fill == CW'(1)) begin
                r_byte1_x <= (rx == CHR_X);
            end
        end
    end

    // conversion datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_end       <= r_fill - CW'(1);
                r_idx       <= IW'(1);
                r_lead      <= 1'b1;
                r_neg       <= 1'b0;
                r_acc       <= '0;
                r_id        <= is_b;
                r_res_good  <= (r_fill != '0) && sum_ok;
                r_res_known <= (r_fill != '0) && sum_ok && (is_a || is_b);
                r_res_batt  <= (r_fill >= CW'(3)) && r_byte1_x;
            end
            ST_WALK: begin
                r_idx <= idx_nxt[IW-1:0];
                if (is_digit(ram_rdata)) begin
                    r_acc  <= alu_rsp.y;
                    r_lead <= 1'b0;
                end else if (r_lead &&
                             ((ram_rdata == CHR_PLUS) || (ram_rdata == CHR_MINUS))) begin
                    r_neg  <= (ram_rdata == CHR_MINUS);
                    r_lead <= 1'b0;
                end
            end
            ST_SIGN: begin
                if (r_neg) begin
                    r_acc <= alu_rsp.y;
                end
            end
            ST_BIAS: begin
                // a zero conversion keeps the last value
                r_acc <= (r_acc == 8'h00) ? r_value[r_id] : alu_rsp.y;
            end
            ST_OFFS: r_acc <= alu_rsp.y;
            default: r_acc <= r_acc;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && out_free) begin
            if (r_res_known) begin
                r_m_tdata <= {r_max[r_id], r_min[r_id], r_value[r_id]};
                r_m_tuser <= {r_res_batt, (r_id ? ID_B : ID_A), 1'b1};
            end else begin
                r_m_tdata <= '0;
                r_m_tuser <= {r_res_batt && r_res_good, ID_NONE, r_res_good};
            end
        end
    end

endmodule

`default_nettype wire

[test/sensor_telegram_deframer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_telegram_deframer_tb - self-checking bench for the telegram deframer
// Feeds received bytes and clear commands from a queue of pending items, keeps
// its own model of framing, checksum, payload conversion and min/max tracking,
// and compares every result item field by field. Both stream sides idle at
// random; offsets are rewritten between phases once the block has drained.
// ----------------------------------------------------------------------------

module sensor_telegram_deframer_tb;

    import stdf_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 30;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_ITEMS   = 245;

    // what the driver does with one queue entry
    typedef enum logic [1:0] {
        ACT_ITEM,
        ACT_CONFIG,
        ACT_DRAIN,
        ACT_HOLD
    } t_action;

    typedef struct packed {
        t_action               kind;
        logic                  func;
        logic [7:0]            data;     // rx_byte, or register value
        logic [CFG_IDX_W-1:0]  reg_idx;
    } t_stim;

    typedef struct packed {
        logic        good;
        logic [1:0]  id;
        logic        batt;
        logic [7:0]  reading;
        logic [7:0]  lowest;
        logic [7:0]  highest;
    } t_telegram_result;

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = REG_OFFSET_A;
    logic [7:0]            i_cfg_data    = 8'h00;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic [0:0]            s_axis_tuser  = 1'b0;    // [0] func
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;            // [7:0] reading, [15:8] lowest,
                                                    // [23:16] highest
    logic [3:0]            m_axis_tuser;            // [0] frame_good, [2:1] sensor_id,
                                                    // [3] battery_low

    sensor_telegram_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    t_stim             pending_q[$];
    t_telegram_result  telegram_results_q[$];
    logic [7:0]        body_q[$];              // telegram under construction

    int    items_made   = 0;
    int    fail_count   = 0;
    int    cyc_count    = 0;
    logic  item_taken   = 1'b0;   // item accepted at the last rising edge
    logic  stim_done    = 1'b0;
    logic  draining     = 1'b0;
    int    settle_left  = 0;
    int    gap_left     = 0;
    logic  hold_toggle  = 1'b0;   // flipped by the driver to ask for a long hold
    logic  hold_seen    = 1'b0;
    int    sink_wait    = 0;

    // model state: telegram assembly
    logic        tele_open;
    int          tele_fill;
    logic [7:0]  tele_sum;
    logic [7:0]  tele_bytes[FRAME_BYTES_DEF];

    // model state: per sensor, index 0 = A, 1 = B
    logic [7:0]         sensor_offset[2];
    logic signed [7:0]  sensor_reading[2];
    logic signed [7:0]  sensor_lowest[2];
    logic signed [7:0]  sensor_highest[2];
    logic               sensor_tracked[2];

    // ------------------------------------------------------------------------
    // model of the block
    // ------------------------------------------------------------------------

    // leading blanks, optional sign, then decimal digits over bytes 1 .. stop-1,
    // all modulo 256
    function automatic logic [7:0] payload_value(input int stop);
        int          k;
        logic        minus;
        logic [7:0]  acc;
        k     = 1;
        minus = 1'b0;
        acc   = 8'h00;
        while (k < stop && (tele_bytes[k] == CHR_SPACE ||
               (tele_bytes[k] >= CHR_TAB && tele_bytes[k] <= CHR_CR)))
            k++;
        if (k < stop && (tele_bytes[k] == CHR_PLUS || tele_bytes[k] == CHR_MINUS)) begin
            minus = (tele_bytes[k] == CHR_MINUS);
            k++;
        end
        while (k < stop && tele_bytes[k] >= CHR_ZERO && tele_bytes[k] <= CHR_NINE) begin
            acc = acc * 8'd10 + (tele_bytes[k] - CHR_ZERO);
            k++;
        end
        return minus ? 8'(-acc) : acc;
    endfunction

    task automatic deframe_item(input logic func, input logic [7:0] b,
                                output logic made, output t_telegram_result res);
        int                 n;
        int                 sid;
        logic [7:0]         last;
        logic signed [7:0]  v;
        made = 1'b0;
        res  = '0;
        sid  = -1;
        if (func) begin
            // clear only forgets min/max; the next reading re-seeds them
            sensor_tracked[0] = 1'b0;
            sensor_tracked[1] = 1'b0;
        end else if (b == ETX_CODE && tele_open) begin
            n         = tele_fill;
            tele_open = 1'b0;
            tele_fill = 0;
            made      = 1'b1;
            last      = (n != 0) ? tele_bytes[n - 1] : 8'h00;
            // empty telegram or bad sum: all-zero result
            if (n != 0 && 8'(tele_sum - last) == last) begin
                res.good = 1'b1;
                res.batt = (n >= 3) && (tele_bytes[1] == CHR_X);
                if (n >= 2 && tele_bytes[0] == CHR_A)
                    sid = 0;
                else if (n >= 2 && tele_bytes[0] == CHR_B)
                    sid = 1;
                if (sid >= 0) begin
                    v = payload_value(n - 1);
                    if (v != 0)
                        v = v - VALUE_BIAS + sensor_offset[sid];
                    else
                        v = sensor_reading[sid];
                    sensor_reading[sid] = v;
                    if (!sensor_tracked[sid]) begin
                        sensor_lowest[sid]  = v;
                        sensor_highest[sid] = v;
                        sensor_tracked[sid] = 1'b1;
                    end else begin
                        if (v < sensor_lowest[sid])
                            sensor_lowest[sid] = v;
                        if (v > sensor_highest[sid])
                            sensor_highest[sid] = v;
                    end
                    res.id      = (sid == 0) ? ID_A : ID_B;
                    res.reading = sensor_reading[sid];
                    res.lowest  = sensor_lowest[sid];
                    res.highest = sensor_highest[sid];
                end
            end
        end else if (b == STX_CODE) begin
            // also restarts an open telegram
            tele_open = 1'b1;
            tele_sum  = 8'h00;
            tele_fill = 0;
        end else if (tele_open) begin
            if (tele_fill < FRAME_BYTES_DEF) begin
                tele_bytes[tele_fill] = b;
                tele_fill++;
                tele_sum = tele_sum + b;
            end else begin
                // overflow drops the telegram silently
                tele_open = 1'b0;
                tele_fill = 0;
            end
        end
    endtask

    task automatic check_field(input string what, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, what, exp_v, act_v);
        end
    endtask

    // ------------------------------------------------------------------------
    // monitor and model update, both at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_telegram_result  want;
        t_telegram_result  got;
        logic              made;
        if (!i_rst_n) begin
            item_taken <= 1'b0;
            tele_open  = 1'b0;
            tele_fill  = 0;
            tele_sum   = 8'h00;
            for (int s = 0; s < 2; s++) begin
                sensor_offset[s]  = 8'h00;
                sensor_reading[s] = 8'sd0;
                sensor_lowest[s]  = 8'sd0;
                sensor_highest[s] = 8'sd0;
                sensor_tracked[s] = 1'b0;
            end
        end else begin
            item_taken <= s_axis_tvalid && s_axis_tready;

            if (i_cfg_we) begin
                if (i_cfg_idx == REG_OFFSET_A)
                    sensor_offset[0] = i_cfg_data;
                else
                    sensor_offset[1] = i_cfg_data;
            end

            if (m_axis_tvalid && m_axis_tready) begin
                got.good    = m_axis_tuser[0];
                got.id      = m_axis_tuser[2:1];
                got.batt    = m_axis_tuser[3];
                got.reading = m_axis_tdata[7:0];
                got.lowest  = m_axis_tdata[15:8];
                got.highest = m_axis_tdata[23:16];
                if (telegram_results_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result item, expected none, actual %h",
                             $time, got);
                end else begin
                    want = telegram_results_q.pop_front();
                    check_field("frame_good",  want.good,    got.good);
                    check_field("sensor_id",   want.id,      got.id);
                    check_field("battery_low", want.batt,    got.batt);
                    check_field("reading",     want.reading, got.reading);
                    check_field("lowest",      want.lowest,  got.lowest);
                    check_field("highest",     want.highest, got.highest);
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                deframe_item(s_axis_tuser[0], s_axis_tdata, made, want);
                if (made)
                    telegram_results_q.push_back(want);
            end
        end
    end

    // ------------------------------------------------------------------------
    // idling: quiet stretches with no gaps, otherwise mostly short gaps
    // ------------------------------------------------------------------------
    function automatic int idle_length();
        int r;
        if ((cyc_count / 256) % 4 == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // driver: one queue entry at a time, inputs change at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : item_driver
        t_stim  act;
        logic   vld_nxt;
        logic   we_nxt;
        vld_nxt = s_axis_tvalid;
        we_nxt  = 1'b0;
        if (!i_rst_n) begin
            vld_nxt = 1'b0;
        end else if (s_axis_tvalid && !item_taken) begin
            // hold the item until the block takes it
        end else if (gap_left != 0) begin
            vld_nxt = 1'b0;
            gap_left <= gap_left - 1;
        end else if (draining) begin
            // wait for every result, then let the sequencer settle
            vld_nxt = 1'b0;
            if (telegram_results_q.size() == 0) begin
                if (settle_left == 0)
                    draining <= 1'b0;
                else
                    settle_left <= settle_left - 1;
            end
        end else if (pending_q.size() != 0) begin
            act     = pending_q.pop_front();
            vld_nxt = 1'b0;
            case (act.kind)
                ACT_ITEM: begin
                    vld_nxt = 1'b1;
                    s_axis_tdata <= act.data;
                    s_axis_tuser <= act.func;
                    gap_left     <= idle_length();
                end
                ACT_CONFIG: begin
                    we_nxt = 1'b1;
                    i_cfg_idx  <= act.reg_idx;
                    i_cfg_data <= act.data;
                end
                ACT_DRAIN: begin
                    draining    <= 1'b1;
                    settle_left <= SETTLE_CYCLES;
                end
                ACT_HOLD: begin
                    hold_toggle <= ~hold_toggle;
                end
                default: begin
                end
            endcase
        end else begin
            vld_nxt = 1'b0;
            stim_done <= 1'b1;
        end
        s_axis_tvalid <= vld_nxt;
        i_cfg_we      <= we_nxt;
    end

    // ------------------------------------------------------------------------
    // result side: random stalls plus one long hold on request
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : result_sink
        int    stall;
        logic  rdy_nxt;
        rdy_nxt = 1'b1;
        if (!i_rst_n) begin
            rdy_nxt = 1'b0;
        end else if (hold_toggle != hold_seen) begin
            // long hold: output register fills and the input stalls behind it
            hold_seen <= hold_toggle;
            sink_wait <= LONG_HOLD;
            rdy_nxt = 1'b0;
        end else if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
            rdy_nxt = 1'b0;
        end else begin
            stall = idle_length();
            if (stall != 0) begin
                rdy_nxt = 1'b0;
                sink_wait <= stall - 1;
            end
        end
        m_axis_tready <= rdy_nxt;
    end

    // ------------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------------
    task automatic put_byte(input logic [7:0] b);
        pending_q.push_back('{kind: ACT_ITEM, func: 1'b0, data: b, reg_idx: REG_OFFSET_A});
        items_made++;
    endtask

    task automatic put_clear(input logic [7:0] b);
        pending_q.push_back('{kind: ACT_ITEM, func: 1'b1, data: b, reg_idx: REG_OFFSET_A});
        items_made++;
    endtask

    // offsets only change once the block has gone quiet
    task automatic put_offsets(input logic [7:0] off_a, input logic [7:0] off_b);
        pending_q.push_back('{kind: ACT_DRAIN, func: 1'b0, data: 8'h00,
                              reg_idx: REG_OFFSET_A});
        pending_q.push_back('{kind: ACT_CONFIG, func: 1'b0, data: off_a,
                              reg_idx: REG_OFFSET_A});
        pending_q.push_back('{kind: ACT_CONFIG, func: 1'b0, data: off_b,
                              reg_idx: REG_OFFSET_B});
    endtask

    // STX, body_q, checksum, ETX; a bad sum is offset by a nonzero amount
    task automatic put_telegram(input logic sum_ok);
        logic [7:0] s;
        s = 8'h00;
        put_byte(STX_CODE);
        foreach (body_q[k]) begin
            put_byte(body_q[k]);
            s = s + body_q[k];
        end
        if (!sum_ok)
            s = s + 8'($urandom_range(1, 255));
        put_byte(s);
        put_byte(ETX_CODE);
        body_q.delete();
    endtask

    // well-formed shape with random content; store room is sensor byte,
    // four payload characters and the checksum
    task automatic random_telegram();
        int r;
        int room;
        r    = $urandom_range(0, 99);
        room = FRAME_BYTES_DEF - 2;
        body_q.delete();
        body_q.push_back(r < 45 ? CHR_A : r < 90 ? CHR_B : 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) == 0) begin
            body_q.push_back(CHR_X);
            room--;
        end
        while (room > 0 && $urandom_range(0, 3) == 0) begin
            body_q.push_back($urandom_range(0, 1) ? CHR_SPACE
                                                   : 8'(CHR_TAB + $urandom_range(0, 4)));
            room--;
        end
        if (room > 0 && $urandom_range(0, 1) == 1) begin
            body_q.push_back($urandom_range(0, 1) ? CHR_MINUS : CHR_PLUS);
            room--;
        end
        while (room > 0 && $urandom_range(0, 5) != 0) begin
            body_q.push_back(8'(CHR_ZERO + $urandom_range(0, 9)));
            room--;
        end
        if (room > 0 && $urandom_range(0, 4) == 0)
            body_q.push_back(8'($urandom_range(0, 255)));
        put_telegram($urandom_range(0, 9) != 0);
    endtask

    task automatic random_phase(input int goal);
        int r;
        while (items_made < goal) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                random_telegram();
            end else if (r < 80) begin
                put_clear(8'($urandom_range(0, 255)));
            end else if (r < 88) begin
                repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
            end else if (r < 93) begin
                // one byte too many
                put_byte(STX_CODE);
                repeat (FRAME_BYTES_DEF + 1) put_byte(8'($urandom_range(CHR_ZERO, CHR_NINE)));
            end else if (r < 97) begin
                put_byte(STX_CODE);
                put_byte(ETX_CODE);
            end else begin
                // abandoned start, then a fresh telegram
                put_byte(STX_CODE);
                put_byte(CHR_A);
                random_telegram();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------------
    initial begin
        // directed part
        put_offsets(8'hEC, 8'h0F);
        put_byte(8'hFF);                       // outside a telegram: ignored
        put_byte(ETX_CODE);                    // ETX outside too
        put_byte(STX_CODE);                    // empty telegram
        put_byte(ETX_CODE);
        put_byte(STX_CODE);                    // restart, battery flag, no digits
        put_byte(CHR_B);
        body_q = {CHR_A, CHR_X};
        put_telegram(1'b1);
        body_q = {CHR_B, CHR_SPACE, CHR_MINUS, CHR_NINE, CHR_NINE};   // full store, wraps
        put_telegram(1'b1);
        body_q.delete();                       // checksum only: good, no sensor
        put_telegram(1'b1);
        body_q = {CHR_A, 8'h31};               // bad sum
        put_telegram(1'b0);
        put_clear(8'hFF);
        put_byte(STX_CODE);                    // overflow
        repeat (FRAME_BYTES_DEF + 1) put_byte(CHR_NINE);

        // random phases over several offset settings
        put_offsets(8'h80, 8'h7F);
        random_phase(items_made + PHASE_ITEMS);
        put_offsets(8'h7F, 8'h80);
        pending_q.push_back('{kind: ACT_HOLD, func: 1'b0, data: 8'h00,
                              reg_idx: REG_OFFSET_A});
        random_phase(items_made + PHASE_ITEMS);
        put_offsets(8'h00, 8'h00);
        random_phase(items_made + PHASE_ITEMS);
        put_offsets(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        random_phase(items_made + PHASE_ITEMS);
        put_offsets(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        random_phase(items_made + PHASE_ITEMS);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (stim_done && telegram_results_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("sensor_telegram_deframer_tb OK");
        else
            $display("sensor_telegram_deframer_tb NOT OK");
        $finish;
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc_count <= cyc_count + 1;
        if (cyc_count >= CYCLE_LIMIT) begin
            $display("sensor_telegram_deframer_tb NOT OK");
            $finish;
        end
    end

endmodule
